// ===== rtl/wat_pkg.sv =====
// shared constants, types and the tick table for the window autorange block
`timescale 1ns / 1ps
`default_nettype none
package wat_pkg;

   localparam int WINDOW_LEN = 30;
   localparam int CNT_W      = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;

   localparam int SAMPLE_W = 16;
   localparam int TICK_W   = 13;
   localparam int RANGE_W  = 17;
   localparam int DIFF_W   = 15;
   localparam int DIV_CNT_W = $clog2(SAMPLE_W);

   localparam int TICK_TABLE_LEN = 9;
   localparam logic [TICK_W-1:0] TICK_FALLBACK = 13'd5;
   localparam logic [TICK_W-1:0] TICK_TABLE [TICK_TABLE_LEN] = '{
      13'd1, 13'd5, 13'd10, 13'd25, 13'd50, 13'd250, 13'd500, 13'd2500, 13'd5000
   };

   // reciprocal of five, exact for spans below 2^18
   localparam logic [15:0] RECIP5      = 16'd52429;
   localparam int          RECIP5_SHIFT = 18;

   typedef struct packed {
      logic shift;   // every cell takes its neighbour's value
      logic load;    // head cell takes the new sample instead of the tail
   } cell_ctrl_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // first table entry above diff, else the fallback
   function automatic logic [TICK_W-1:0] tick_select(input logic [DIFF_W-1:0] diff);
      logic [TICK_W-1:0] pick;
      pick = TICK_FALLBACK;
      for (int i = TICK_TABLE_LEN - 1; i >= 0; i--) begin
         if ({2'b00, diff} < {4'b0000, TICK_TABLE[i]}) begin
            pick = TICK_TABLE[i];
         end
      end
      return pick;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/wat_cell.sv =====
// one window cell: holds a sample and passes it down the chain
`timescale 1ns / 1ps
`default_nettype none
module wat_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wat_pkg::cell_ctrl_type ctrl,
   input  wire wat_pkg::sample_type   load_in,
   input  wire wat_pkg::sample_type   chain_in,
   output wat_pkg::sample_type        sample_out
);
   import wat_pkg::*;

   sample_type sample_ff;
   sample_type sample_in;

   always_comb begin
      sample_in = sample_ff;
      if (ctrl.shift) begin
         sample_in = ctrl.load ? load_in : chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule
`default_nettype wire

// ===== rtl/wat_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module wat_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [wat_pkg::SAMPLE_W-1:0]  dividend,
   input  wire logic [wat_pkg::TICK_W-1:0]    divisor,
   output logic                               done,
   output logic [wat_pkg::SAMPLE_W-1:0]       quotient
);
   import wat_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0]  dvd_ff, dvd_in;
   logic [TICK_W-1:0]    rem_ff, rem_in;
   logic [TICK_W:0]      trial;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, dvd_ff[SAMPLE_W-1]};
      fits   = trial >= {1'b0, divisor};
      run_in = run_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = fits ? TICK_W'(trial - {1'b0, divisor}) : TICK_W'(trial);
         dvd_in = {dvd_ff[SAMPLE_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(SAMPLE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
`default_nettype wire

// ===== rtl/window_autorange_ticks.sv =====
// top level: sliding window min/max and tick-aligned axis range
`timescale 1ns / 1ps
`default_nettype none
//
// channel    direction  handshake              payload
// req_       in         req_valid / req_stall  req_new_sample
// rsp_       out        rsp_valid / rsp_stall  rsp_window_min, rsp_window_max,
//                                              rsp_tick_step, rsp_range_low,
//                                              rsp_range_high
//
// for each request the scan walks the whole window round the cell chain once,
// then a 16-step divider aligns the minimum to the tick
// reset is synchronous, active high, and clears the window to zero
// requests are stalled while a request is being worked on; a finished result
// waits in the output register without holding up the next request
//
module window_autorange_ticks (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [wat_pkg::SAMPLE_W-1:0]  req_new_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [wat_pkg::SAMPLE_W-1:0]       rsp_window_min,
   output logic signed [wat_pkg::SAMPLE_W-1:0]       rsp_window_max,
   output logic        [wat_pkg::TICK_W-1:0]         rsp_tick_step,
   output logic signed [wat_pkg::RANGE_W-1:0]        rsp_range_low,
   output logic signed [wat_pkg::RANGE_W-1:0]        rsp_range_high
);
   import wat_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;   // waiting for a request
   localparam logic [2:0] ST_SCAN = 3'd1;   // window rotating past the tail
   localparam logic [2:0] ST_DIFF = 3'd2;   // span divided by five
   localparam logic [2:0] ST_TICK = 3'd3;   // tick looked up
   localparam logic [2:0] ST_DIVS = 3'd4;   // divider started
   localparam logic [2:0] ST_DIVW = 3'd5;   // divider running
   localparam logic [2:0] ST_MUL  = 3'd6;   // quotient times tick
   localparam logic [2:0] ST_FIN  = 3'd7;   // bounds into the output register

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   sample_type          min_ff, min_in;
   sample_type          max_ff, max_in;
   logic [DIFF_W-1:0]   diff_ff, diff_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [RANGE_W-1:0]  prod_ff, prod_in;

   logic                rsp_valid_ff, rsp_valid_in;
   sample_type          rsp_min_ff, rsp_max_ff;
   logic [TICK_W-1:0]   rsp_tick_ff;
   logic signed [RANGE_W-1:0] rsp_low_ff, rsp_high_ff;

   logic                req_take;
   logic                fin_load;
   cell_ctrl_type       cell_ctrl;
   sample_type          cell_q [WINDOW_LEN];
   sample_type          tail;

   logic [RANGE_W-1:0]  span;
   logic [RANGE_W+15:0] span_scaled;
   logic                min_neg;
   logic [SAMPLE_W-1:0] min_mag;
   logic                div_start;
   logic                div_done;
   logic [SAMPLE_W-1:0] div_quot;
   logic [RANGE_W+12:0] quot_times_tick;
   logic signed [RANGE_W:0] aligned;
   logic signed [RANGE_W:0] low_wide;
   logic signed [RANGE_W:0] high_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // the chain: load pushes the new sample in at the head and drops the tail,
   // rotation feeds the tail back to the head so the order comes back intact
   assign cell_ctrl.shift = req_take || (state_ff == ST_SCAN);
   assign cell_ctrl.load  = req_take;
   assign tail = cell_q[WINDOW_LEN-1];

   for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
      if (g == 0) begin : g_head
         wat_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .load_in    (req_new_sample),
            .chain_in   (tail),
            .sample_out (cell_q[g])
         );
      end else begin : g_body
         wat_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .load_in    (cell_q[g-1]),
            .chain_in   (cell_q[g-1]),
            .sample_out (cell_q[g])
         );
      end
   end

   // span is never negative; divide by five through the reciprocal
   assign span        = RANGE_W'({max_ff[SAMPLE_W-1], max_ff} - {min_ff[SAMPLE_W-1], min_ff});
   assign span_scaled = span * RECIP5;

   // truncating division works on the magnitude of the minimum
   assign min_neg   = min_ff[SAMPLE_W-1];
   assign min_mag   = min_neg ? SAMPLE_W'(-{min_ff[SAMPLE_W-1], min_ff}) : min_ff;
   assign div_start = (state_ff == ST_DIVS);

   wat_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (min_mag),
      .divisor  (tick_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign quot_times_tick = {1'b0, div_quot} * tick_ff;

   // bounds: aligned minimum less one tick, then five ticks up
   assign aligned   = min_neg ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
   assign low_wide  = aligned - $signed({5'b00000, tick_ff});
   assign high_wide = low_wide + $signed(18'({5'b00000, tick_ff} * 18'd5));

   assign fin_load = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      diff_in  = diff_ff;
      tick_in  = tick_ff;
      prod_in  = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               min_in = tail;
               max_in = tail;
            end else begin
               if (tail < min_ff) begin
                  min_in = tail;
               end
               if (tail > max_ff) begin
                  max_in = tail;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WINDOW_LEN - 1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = span_scaled[RECIP5_SHIFT +: DIFF_W];
            state_in = ST_TICK;
         end
         ST_TICK: begin
            tick_in  = tick_select(diff_ff);
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = quot_times_tick[RANGE_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || fin_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff  <= min_in;
      max_ff  <= max_in;
      diff_ff <= diff_in;
      tick_ff <= tick_in;
      prod_ff <= prod_in;
      if (fin_load) begin
         rsp_min_ff  <= min_ff;
         rsp_max_ff  <= max_ff;
         rsp_tick_ff <= tick_ff;
         rsp_low_ff  <= RANGE_W'(low_wide);
         rsp_high_ff <= RANGE_W'(high_wide);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_min = rsp_min_ff;
   assign rsp_window_max = rsp_max_ff;
   assign rsp_tick_step  = rsp_tick_ff;
   assign rsp_range_low  = rsp_low_ff;
   assign rsp_range_high = rsp_high_ff;

`ifndef ASSERT_OFF
   a_span_five_ticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (RANGE_W'(rsp_range_high - rsp_range_low)
                     == RANGE_W'({4'b0000, rsp_tick_step} * 17'd5)))
      else $error("axis span is not five ticks");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_min <= rsp_window_max))
      else $error("window minimum above maximum");

   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tick_step != '0 && rsp_tick_step <= 13'd5000))
      else $error("tick outside table range");

   a_div_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVW))
      else $error("divider finished outside its wait state");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(WINDOW_LEN - 1)))
      else $error("scan ran past the window");
`endif

endmodule
`default_nettype wire
